// ===== sv/skf_pkg.sv =====
// Package for the scalar Kalman filter core: word geometry, codes and
// saturating fixed-point helpers. No dependencies.
package skf_pkg;

    localparam int DATA_WIDTH  = 32;
    localparam int FRAC_BITS   = 16;
    localparam int NOISE_WIDTH = 31;
    localparam int WIDE_W      = 2 * DATA_WIDTH;
    localparam int NUM_W       = DATA_WIDTH + FRAC_BITS;
    localparam int MUL_STEPS   = DATA_WIDTH;
    localparam int DIV_STEPS   = NUM_W;
    localparam int CNT_W       = $clog2(DIV_STEPS + 1);

    localparam logic MODE_PREDICT = 1'b0;
    localparam logic MODE_UPDATE  = 1'b1;

    localparam logic CFG_PROCESS_NOISE     = 1'b0;
    localparam logic CFG_MEASUREMENT_NOISE = 1'b1;

    localparam logic [NOISE_WIDTH-1:0] PROCESS_NOISE_RESET     = NOISE_WIDTH'(0);
    localparam logic [NOISE_WIDTH-1:0] MEASUREMENT_NOISE_RESET = NOISE_WIDTH'(65536);

    localparam logic signed [DATA_WIDTH-1:0] MAX_POS = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic signed [DATA_WIDTH-1:0] MIN_NEG = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    localparam logic signed [DATA_WIDTH-1:0] ONE     =
        DATA_WIDTH'(1) << FRAC_BITS;
    // First magnitude that no longer fits as a positive word
    localparam logic [WIDE_W-1:0] MAG_LIMIT =
        {{(WIDE_W-DATA_WIDTH){1'b0}}, 1'b1, {(DATA_WIDTH-1){1'b0}}};

    typedef logic signed [DATA_WIDTH-1:0] word_t;
    typedef logic [DATA_WIDTH-1:0]        mag_t;

    function automatic word_t sat_add(input word_t a, input word_t b);
        logic signed [DATA_WIDTH:0] s;
        s = {a[DATA_WIDTH-1], a} + {b[DATA_WIDTH-1], b};
        if (s[DATA_WIDTH] != s[DATA_WIDTH-1])
            return s[DATA_WIDTH] ? MIN_NEG : MAX_POS;
        return s[DATA_WIDTH-1:0];
    endfunction

    function automatic word_t sat_sub(input word_t a, input word_t b);
        logic signed [DATA_WIDTH:0] s;
        s = {a[DATA_WIDTH-1], a} - {b[DATA_WIDTH-1], b};
        if (s[DATA_WIDTH] != s[DATA_WIDTH-1])
            return s[DATA_WIDTH] ? MIN_NEG : MAX_POS;
        return s[DATA_WIDTH-1:0];
    endfunction

    // Apply a sign to a wide magnitude and clamp to the word range
    function automatic word_t sat_mag(input logic neg, input logic [WIDE_W-1:0] v);
        if (!neg)
            return (v >= MAG_LIMIT) ? MAX_POS : word_t'(v[DATA_WIDTH-1:0]);
        if (v >= MAG_LIMIT)
            return MIN_NEG;
        return word_t'(-v[DATA_WIDTH-1:0]);
    endfunction

    function automatic word_t noise_word(input logic [NOISE_WIDTH-1:0] q);
        logic [WIDE_W-1:0] w;
        w = WIDE_W'(q);
        return (w >= MAG_LIMIT) ? MAX_POS : word_t'(w[DATA_WIDTH-1:0]);
    endfunction

    function automatic mag_t mag_of(input word_t v);
        return v[DATA_WIDTH-1] ? mag_t'(-v) : mag_t'(v);
    endfunction

endpackage

// ===== sv/scalar_kalman_filter_core.sv =====
// Scalar Kalman filter core: bit-serial multiplier and restoring divider
// driven by a step sequencer. Depends on skf_pkg.
// A predict runs four serial multiplies, an update runs five multiplies and a divide,
// and an update that faults stops after two multiplies.
// One item at a time: the next is taken the cycle after the result registers.
// Reset zeroes estimate and covariance, Q = 0, R = 1.0.
module scalar_kalman_filter_core (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration write channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic                                cfg_index,
    input  logic [skf_pkg::NOISE_WIDTH-1:0]     cfg_data,
    // input channel
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                mode,
    input  logic signed [skf_pkg::DATA_WIDTH-1:0] drive_input,
    input  logic signed [skf_pkg::DATA_WIDTH-1:0] transition_gain,
    input  logic signed [skf_pkg::DATA_WIDTH-1:0] drive_gain,
    input  logic signed [skf_pkg::DATA_WIDTH-1:0] measurement,
    input  logic signed [skf_pkg::DATA_WIDTH-1:0] predicted_measurement,
    input  logic signed [skf_pkg::DATA_WIDTH-1:0] sensitivity,
    // output channel
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [skf_pkg::DATA_WIDTH-1:0] estimate,
    output logic signed [skf_pkg::DATA_WIDTH-1:0] covariance,
    output logic signed [skf_pkg::DATA_WIDTH-1:0] gain,
    output logic signed [skf_pkg::DATA_WIDTH-1:0] residual,
    output logic                                divide_fault
);
    import skf_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE, ST_LOAD, ST_MUL, ST_MFIN, ST_POST, ST_DIV, ST_DFIN, ST_OUT
    } state_t;

    typedef enum logic [3:0] {
        OP_FX, OP_BU, OP_FP, OP_PF, OP_PH, OP_HPHT, OP_DIV, OP_KY, OP_KH, OP_PIKH
    } op_t;

    state_t                   state_reg;
    op_t                      op_reg;
    logic [CNT_W-1:0]         cnt_reg;

    logic [NOISE_WIDTH-1:0]   q_reg;
    logic [NOISE_WIDTH-1:0]   r_reg;
    word_t                    x_reg;
    word_t                    p_reg;

    // p1: F or H, p2: B or z, p3: u or hx
    word_t                    p1_reg;
    word_t                    p2_reg;
    word_t                    p3_reg;
    word_t                    t1_reg;
    word_t                    t2_reg;
    word_t                    mres_reg;
    word_t                    gain_reg;
    word_t                    resid_reg;
    logic                     fault_reg;

    mag_t                     mcand_reg;
    mag_t                     mpl_reg;
    mag_t                     acc_reg;
    mag_t                     rem_reg;
    logic [NUM_W-1:0]         num_reg;
    logic                     neg_reg;

    logic                     out_valid_reg;
    word_t                    est_out_reg;
    word_t                    cov_out_reg;
    word_t                    gain_out_reg;
    word_t                    resid_out_reg;
    logic                     fault_out_reg;

    word_t                    opa;
    word_t                    opb;
    logic [DATA_WIDTH:0]      mul_sum;
    logic [DATA_WIDTH:0]      div_trial;
    logic                     div_ge;
    logic [WIDE_W-1:0]        prod;
    logic [WIDE_W-1:0]        prod_mag;
    logic                     prod_inc;
    word_t                    s_val;

    assign cfg_ready    = 1'b1;
    assign in_stall     = (state_reg != ST_IDLE);
    assign out_valid    = out_valid_reg;
    assign estimate     = est_out_reg;
    assign covariance   = cov_out_reg;
    assign gain         = gain_out_reg;
    assign residual     = resid_out_reg;
    assign divide_fault = fault_out_reg;

    always_comb
    begin
        unique case (op_reg)
            OP_FX:   begin opa = p1_reg;   opb = x_reg;     end
            OP_BU:   begin opa = p2_reg;   opb = p3_reg;    end
            OP_FP:   begin opa = p1_reg;   opb = p_reg;     end
            OP_PF:   begin opa = t1_reg;   opb = p1_reg;    end
            OP_PH:   begin opa = p_reg;    opb = p1_reg;    end
            OP_HPHT: begin opa = p1_reg;   opb = t1_reg;    end
            OP_DIV:  begin opa = t1_reg;   opb = t2_reg;    end
            OP_KY:   begin opa = gain_reg; opb = resid_reg; end
            OP_KH:   begin opa = gain_reg; opb = p1_reg;    end
            OP_PIKH: begin opa = p_reg;    opb = t2_reg;    end
            default: begin opa = p_reg;    opb = t2_reg;    end
        endcase
    end

    assign mul_sum   = {1'b0, acc_reg} + {1'b0, (mpl_reg[0] ? mcand_reg : '0)};
    assign div_trial = {rem_reg, num_reg[NUM_W-1]};
    assign div_ge    = (div_trial >= {1'b0, mcand_reg});
    assign prod      = {acc_reg, mpl_reg};
    assign prod_inc  = neg_reg && (prod[FRAC_BITS-1:0] != '0);
    // Floor of a negative product rounds its magnitude up
    assign prod_mag  = (prod >> FRAC_BITS) + WIDE_W'(prod_inc);
    assign s_val     = sat_add(mres_reg, noise_word(r_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            op_reg        <= OP_FX;
            cnt_reg       <= '0;
            q_reg         <= PROCESS_NOISE_RESET;
            r_reg         <= MEASUREMENT_NOISE_RESET;
            x_reg         <= '0;
            p_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_PROCESS_NOISE:     q_reg <= cfg_data;
                    CFG_MEASUREMENT_NOISE: r_reg <= cfg_data;
                endcase
            end

            // ST_OUT decides the output valid on its own
            if (out_valid_reg && !out_stall && state_reg != ST_OUT)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        gain_reg  <= '0;
                        resid_reg <= '0;
                        fault_reg <= 1'b0;
                        if (mode == MODE_PREDICT)
                        begin
                            p1_reg <= transition_gain;
                            p2_reg <= drive_gain;
                            p3_reg <= drive_input;
                            op_reg <= OP_FX;
                        end
                        else
                        begin
                            p1_reg <= sensitivity;
                            p2_reg <= measurement;
                            p3_reg <= predicted_measurement;
                            op_reg <= OP_PH;
                        end
                        state_reg <= ST_LOAD;
                    end
                end

                ST_LOAD:
                begin
                    neg_reg   <= opa[DATA_WIDTH-1] ^ opb[DATA_WIDTH-1];
                    mcand_reg <= (op_reg == OP_DIV) ? mag_of(opb) : mag_of(opa);
                    mpl_reg   <= mag_of(opb);
                    acc_reg   <= '0;
                    rem_reg   <= '0;
                    num_reg   <= {mag_of(opa), {FRAC_BITS{1'b0}}};
                    cnt_reg   <= '0;
                    state_reg <= (op_reg == OP_DIV) ? ST_DIV : ST_MUL;
                end

                ST_MUL:
                begin
                    acc_reg <= mul_sum[DATA_WIDTH:1];
                    mpl_reg <= {mul_sum[0], mpl_reg[DATA_WIDTH-1:1]};
                    cnt_reg <= cnt_reg + CNT_W'(1);
                    if (cnt_reg == CNT_W'(MUL_STEPS - 1))
                        state_reg <= ST_MFIN;
                end

                ST_MFIN:
                begin
                    mres_reg  <= sat_mag(neg_reg, prod_mag);
                    state_reg <= ST_POST;
                end

                ST_POST:
                begin
                    state_reg <= ST_LOAD;
                    unique case (op_reg)
                        OP_FX:
                        begin
                            t1_reg <= mres_reg;
                            op_reg <= OP_BU;
                        end
                        OP_BU:
                        begin
                            x_reg  <= sat_add(t1_reg, mres_reg);
                            op_reg <= OP_FP;
                        end
                        OP_FP:
                        begin
                            t1_reg <= mres_reg;
                            op_reg <= OP_PF;
                        end
                        OP_PF:
                        begin
                            p_reg     <= sat_add(mres_reg, noise_word(q_reg));
                            state_reg <= ST_OUT;
                        end
                        OP_PH:
                        begin
                            t1_reg <= mres_reg;
                            op_reg <= OP_HPHT;
                        end
                        OP_HPHT:
                        begin
                            resid_reg <= sat_sub(p2_reg, p3_reg);
                            t2_reg    <= s_val;
                            // zero uncertainty: hold the state and flag it
                            if (s_val == '0)
                            begin
                                fault_reg <= 1'b1;
                                state_reg <= ST_OUT;
                            end
                            else
                                op_reg <= OP_DIV;
                        end
                        OP_KY:
                        begin
                            x_reg  <= sat_add(x_reg, mres_reg);
                            op_reg <= OP_KH;
                        end
                        OP_KH:
                        begin
                            t2_reg <= sat_sub(ONE, mres_reg);
                            op_reg <= OP_PIKH;
                        end
                        OP_PIKH:
                        begin
                            p_reg     <= mres_reg;
                            state_reg <= ST_OUT;
                        end
                        default:
                            state_reg <= ST_OUT;
                    endcase
                end

                ST_DIV:
                begin
                    rem_reg <= div_ge ? DATA_WIDTH'(div_trial - {1'b0, mcand_reg})
                                      : div_trial[DATA_WIDTH-1:0];
                    num_reg <= {num_reg[NUM_W-2:0], div_ge};
                    cnt_reg <= cnt_reg + CNT_W'(1);
                    if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                        state_reg <= ST_DFIN;
                end

                ST_DFIN:
                begin
                    gain_reg  <= sat_mag(neg_reg, WIDE_W'(num_reg));
                    op_reg    <= OP_KY;
                    state_reg <= ST_LOAD;
                end

                ST_OUT:
                begin
                    // hold until the output register is free
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_valid_reg <= 1'b1;
                        est_out_reg   <= x_reg;
                        cov_out_reg   <= p_reg;
                        gain_out_reg  <= gain_reg;
                        resid_out_reg <= resid_reg;
                        fault_out_reg <= fault_reg;
                        state_reg     <= ST_IDLE;
                    end
                end

                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule
